// File: rtl/core/hfe_pkg.sv
`default_nettype none
// ============================================================================
// hfe_pkg: shared types, constants and microcode for the Haar evaluator
// Holds the item and result structs, the field widths, the register and
// feature kind codes, and the control store of the corner sequencer.
// ============================================================================
package hfe_pkg;

  localparam int unsigned MAX_DIM_DEFAULT = 32;

  localparam int unsigned COORD_W    = 5;
  localparam int unsigned VALUE_W    = 24;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned RESPONSE_W = 29;
  localparam int unsigned SKIP_W     = 5;
  localparam int unsigned LIMIT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_EVALUATE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_TWO_H   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TWO_V   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_THREE_H = 3'd2;
  localparam logic [KIND_W-1:0] KIND_THREE_V = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CHECKER = 3'd4;

  typedef struct packed {
    logic                      cmd;
    logic [COORD_W-1:0]        entry_col;
    logic [COORD_W-1:0]        entry_row;
    logic [VALUE_W-1:0]        entry_value;
    logic [KIND_W-1:0]         feature_kind;
    logic [COORD_W-1:0]        feature_left;
    logic [COORD_W-1:0]        feature_top;
    logic [COORD_W-1:0]        feature_width;
    logic [COORD_W-1:0]        feature_height;
  } hfe_item_t;

  typedef struct packed {
    logic signed [RESPONSE_W-1:0] response;
    logic [SKIP_W-1:0]            skipped_points;
  } hfe_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } hfe_state_t;

  typedef enum logic {
    UOP_NOP,
    UOP_CORNER
  } ucode_op_t;

  // Offset of a corner from the feature's left or top edge.
  typedef enum logic [2:0] {
    OFS_ZERO,
    OFS_HALF,
    OFS_THIRD,
    OFS_TWO_THIRDS,
    OFS_FULL
  } ofs_t;

  typedef struct packed {
    ucode_op_t op;
    ofs_t      xsel;
    ofs_t      ysel;
    logic      neg;
    logic      last;
  } ucode_t;

  // Truncating division of a 5-bit value by 3: (v * 11) >> 5 is exact here.
  function automatic logic [3:0] div3(input logic [COORD_W-1:0] v);
    logic [8:0] p;
    p = {4'b0, v} * 9'd11;
    return p[8:5];
  endfunction

  // Control store. Steps 4r..4r+3 visit the four corners of rectangle r in
  // the order top-left, top-right, bottom-left, bottom-right.
  function automatic ucode_t ucode_rom(input logic [KIND_W-1:0] kind,
                                       input logic [STEP_W-1:0] step);
    ofs_t       x0;
    ofs_t       x1;
    ofs_t       y0;
    ofs_t       y1;
    logic       rect_neg;
    logic [1:0] last_rect;
    logic       known;
    ucode_t     w;
    x0        = OFS_ZERO;
    x1        = OFS_FULL;
    y0        = OFS_ZERO;
    y1        = OFS_FULL;
    rect_neg  = 1'b0;
    last_rect = 2'd3;
    known     = 1'b1;
    case (kind)
      KIND_TWO_H: begin
        last_rect = 2'd1;
        if (step[3:2] == 2'd0) begin
          x1 = OFS_HALF;
        end else begin
          x0 = OFS_HALF;
          rect_neg = 1'b1;
        end
      end
      KIND_TWO_V: begin
        last_rect = 2'd1;
        if (step[3:2] == 2'd0) begin
          y1 = OFS_HALF;
          rect_neg = 1'b1;
        end else begin
          y0 = OFS_HALF;
        end
      end
      KIND_THREE_H: begin
        last_rect = 2'd2;
        if (step[3:2] == 2'd0) begin
          x1 = OFS_THIRD;
          rect_neg = 1'b1;
        end else if (step[3:2] == 2'd1) begin
          x0 = OFS_THIRD;
          x1 = OFS_TWO_THIRDS;
        end else begin
          x0 = OFS_TWO_THIRDS;
          rect_neg = 1'b1;
        end
      end
      KIND_THREE_V: begin
        last_rect = 2'd2;
        if (step[3:2] == 2'd0) begin
          y1 = OFS_THIRD;
          rect_neg = 1'b1;
        end else if (step[3:2] == 2'd1) begin
          y0 = OFS_THIRD;
          y1 = OFS_TWO_THIRDS;
        end else begin
          y0 = OFS_TWO_THIRDS;
          rect_neg = 1'b1;
        end
      end
      KIND_CHECKER: begin
        case (step[3:2])
          2'd0: begin
            x1 = OFS_HALF;
            y1 = OFS_HALF;
          end
          2'd1: begin
            x0 = OFS_HALF;
            y1 = OFS_HALF;
            rect_neg = 1'b1;
          end
          2'd2: begin
            x1 = OFS_HALF;
            y0 = OFS_HALF;
            rect_neg = 1'b1;
          end
          default: begin
            x0 = OFS_HALF;
            y0 = OFS_HALF;
          end
        endcase
      end
      default: known = 1'b0;
    endcase
    w.op   = known ? UOP_CORNER : UOP_NOP;
    w.xsel = (step[1:0] == 2'd1 || step[1:0] == 2'd3) ? x1 : x0;
    w.ysel = (step[1:0] == 2'd2 || step[1:0] == 2'd3) ? y1 : y0;
    w.neg  = rect_neg ^ (step[1:0] == 2'd1 || step[1:0] == 2'd2);
    w.last = !known || (step[3:2] == last_rect && step[1:0] == 2'd3);
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/hfe_ram.sv
`default_nettype none
// ============================================================================
// hfe_ram: single-port RAM with registered read
// One access per cycle, either a write or a read, addressed by one port.
// ============================================================================
module hfe_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: rtl/core/haar_feature_evaluator_core.sv
`default_nettype none
// ============================================================================
// haar_feature_evaluator_core: Haar feature response over an integral image
// Loads integral image entries and sums signed corner entries of a feature.
// ============================================================================
// A transfer on the item port is taken when start is high and busy is low.
// A write item stores one integral image entry and busy stays low. An
// evaluate item keeps busy high through the run state, which walks the
// corner steps of the feature kind (8 for the two-rectangle kinds, 12 for
// the three-rectangle kinds, 16 for the checker and 1 for an unknown kind),
// and then the drain state. The single-port integral image memory reads one
// corner per cycle. The result appears in the first cycle that busy is low
// again, with done high for exactly that one cycle; the receiver cannot
// hold it off, so it must take it then. A new item may be started in that
// same cycle. The image size registers are written through the cfg port,
// which is always ready and should only be written while idle.
module haar_feature_evaluator_core #(
  parameter int unsigned MAX_DIM = hfe_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire hfe_pkg::hfe_item_t                 item,
  output logic                                    done,
  output hfe_pkg::hfe_result_t                    result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [hfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hfe_pkg::LIMIT_W-1:0]        cfg_data
);

  // Depth and address width of the integral image store.
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  // Width used for bounds compares; must hold MAX_DIM and any corner column.
  localparam int unsigned CMP_W  = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;
  localparam int unsigned POS_W  = hfe_pkg::COORD_W + 1;

  // Sequencer state and the captured feature description.
  hfe_pkg::hfe_state_t              state;
  hfe_pkg::hfe_state_t              state_next;
  logic [hfe_pkg::STEP_W-1:0]       step;
  logic [hfe_pkg::KIND_W-1:0]       kind;
  logic [hfe_pkg::COORD_W-1:0]      left;
  logic [hfe_pkg::COORD_W-1:0]      top;
  logic [hfe_pkg::COORD_W-1:0]      full_w;
  logic [hfe_pkg::COORD_W-1:0]      full_h;
  logic [3:0]                       half_w;
  logic [3:0]                       half_h;
  logic [3:0]                       third_w;
  logic [3:0]                       third_h;

  // Configuration registers.
  logic [hfe_pkg::LIMIT_W-1:0]      image_width;
  logic [hfe_pkg::LIMIT_W-1:0]      image_height;

  // Accumulation: one corner read is in flight at a time per cycle.
  logic                             pend_valid;
  logic                             pend_neg;
  logic signed [hfe_pkg::RESPONSE_W-1:0] acc;
  logic [hfe_pkg::SKIP_W-1:0]       skip;

  logic                             accept;
  logic                             eval_accept;
  hfe_pkg::ucode_t                  uword;
  logic [hfe_pkg::COORD_W-1:0]      ofs_x;
  logic [hfe_pkg::COORD_W-1:0]      ofs_y;
  logic [POS_W-1:0]                 col;
  logic [POS_W-1:0]                 row;
  logic [CMP_W-1:0]                 lim_w;
  logic [CMP_W-1:0]                 lim_h;
  logic                             in_bounds;
  logic                             issue;
  logic                             wr_en;
  logic [ADDR_W-1:0]                wr_addr;
  logic [ADDR_W-1:0]                rd_addr;
  logic [ADDR_W-1:0]                ram_addr;
  logic [hfe_pkg::VALUE_W-1:0]      ram_rdata;
  logic signed [hfe_pkg::RESPONSE_W-1:0] term;
  logic signed [hfe_pkg::RESPONSE_W-1:0] acc_sum;

  assign busy        = (state != hfe_pkg::ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = start && !busy;
  assign eval_accept = accept && (item.cmd == hfe_pkg::CMD_EVALUATE);

  // Writes outside the store are dropped.
  assign wr_en   = accept && (item.cmd == hfe_pkg::CMD_WRITE)
                   && (int'(item.entry_col) < MAX_DIM)
                   && (int'(item.entry_row) < MAX_DIM);
  assign wr_addr = ADDR_W'(int'(item.entry_row) * MAX_DIM + int'(item.entry_col));

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= hfe_pkg::LIMIT_W'(32);
      image_height <= hfe_pkg::LIMIT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hfe_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == hfe_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Both limits are capped at the store size before the bounds test.
  assign lim_w = ({{(CMP_W - hfe_pkg::LIMIT_W){1'b0}}, image_width} < CMP_W'(MAX_DIM))
                 ? {{(CMP_W - hfe_pkg::LIMIT_W){1'b0}}, image_width} : CMP_W'(MAX_DIM);
  assign lim_h = ({{(CMP_W - hfe_pkg::LIMIT_W){1'b0}}, image_height} < CMP_W'(MAX_DIM))
                 ? {{(CMP_W - hfe_pkg::LIMIT_W){1'b0}}, image_height} : CMP_W'(MAX_DIM);

  // Fetch the control word for the current step.
  assign uword = hfe_pkg::ucode_rom(kind, step);

  always_comb begin
    unique case (uword.xsel)
      hfe_pkg::OFS_ZERO:       ofs_x = '0;
      hfe_pkg::OFS_HALF:       ofs_x = {1'b0, half_w};
      hfe_pkg::OFS_THIRD:      ofs_x = {1'b0, third_w};
      hfe_pkg::OFS_TWO_THIRDS: ofs_x = {third_w, 1'b0};
      hfe_pkg::OFS_FULL:       ofs_x = full_w;
      default:                 ofs_x = '0;
    endcase
    unique case (uword.ysel)
      hfe_pkg::OFS_ZERO:       ofs_y = '0;
      hfe_pkg::OFS_HALF:       ofs_y = {1'b0, half_h};
      hfe_pkg::OFS_THIRD:      ofs_y = {1'b0, third_h};
      hfe_pkg::OFS_TWO_THIRDS: ofs_y = {third_h, 1'b0};
      hfe_pkg::OFS_FULL:       ofs_y = full_h;
      default:                 ofs_y = '0;
    endcase
  end

  assign col = {1'b0, left} + {1'b0, ofs_x};
  assign row = {1'b0, top} + {1'b0, ofs_y};

  assign in_bounds = ({{(CMP_W - POS_W){1'b0}}, col} < lim_w)
                     && ({{(CMP_W - POS_W){1'b0}}, row} < lim_h);
  assign issue     = (state == hfe_pkg::ST_RUN) && (uword.op == hfe_pkg::UOP_CORNER);
  // An in-bounds corner has row and column below the store size.
  assign rd_addr   = ADDR_W'(int'(row) * MAX_DIM + int'(col));
  assign ram_addr  = wr_en ? wr_addr : rd_addr;

  hfe_ram #(
    .WIDTH (hfe_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (wr_en),
    .addr  (ram_addr),
    .wdata (item.entry_value),
    .rdata (ram_rdata)
  );

  // The entry read in the previous step arrives now and is folded in.
  always_comb begin
    if (!pend_valid) begin
      term = '0;
    end else if (pend_neg) begin
      term = -$signed({{(hfe_pkg::RESPONSE_W - hfe_pkg::VALUE_W){1'b0}}, ram_rdata});
    end else begin
      term = $signed({{(hfe_pkg::RESPONSE_W - hfe_pkg::VALUE_W){1'b0}}, ram_rdata});
    end
    acc_sum = acc + term;
  end

  // Next state: the last flag of the control word ends the program.
  always_comb begin
    state_next = state;
    unique case (state)
      hfe_pkg::ST_IDLE:  if (eval_accept) state_next = hfe_pkg::ST_RUN;
      hfe_pkg::ST_RUN:   if (uword.last) state_next = hfe_pkg::ST_DRAIN;
      hfe_pkg::ST_DRAIN: state_next = hfe_pkg::ST_IDLE;
      default:           state_next = hfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter, the read-pending flag and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      pend_valid <= issue && in_bounds;
      done       <= (state == hfe_pkg::ST_DRAIN);
      if (eval_accept) begin
        step <= '0;
      end else if (state == hfe_pkg::ST_RUN) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_neg <= uword.neg;
    if (eval_accept) begin
      kind    <= item.feature_kind;
      left    <= item.feature_left;
      top     <= item.feature_top;
      full_w  <= item.feature_width;
      full_h  <= item.feature_height;
      half_w  <= item.feature_width[hfe_pkg::COORD_W-1:1];
      half_h  <= item.feature_height[hfe_pkg::COORD_W-1:1];
      third_w <= hfe_pkg::div3(item.feature_width);
      third_h <= hfe_pkg::div3(item.feature_height);
      acc     <= '0;
      skip    <= '0;
    end else begin
      acc <= acc_sum;
      if (issue && !in_bounds) begin
        skip <= skip + 1'b1;
      end
    end
    if (state == hfe_pkg::ST_DRAIN) begin
      result.response       <= acc_sum;
      result.skipped_points <= skip;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hfe_checker.sv
`default_nettype none
// ============================================================================
// hfe_checker: port-level assertions for the Haar evaluator
// Watches the command, result and busy ports over time; bound to the top.
// ============================================================================
module hfe_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire hfe_pkg::hfe_item_t            item,
  input wire logic                          done,
  input wire hfe_pkg::hfe_result_t          result
);

  // A result is only shown once the evaluation has finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A write completes in the cycle it is taken.
  a_write_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == hfe_pkg::CMD_WRITE) |=> !busy && !done)
    else $error("write item did not finish at once");

  // An evaluation always occupies the block.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == hfe_pkg::CMD_EVALUATE) |=> busy)
    else $error("evaluate item did not raise busy");

  // At most sixteen corners can be skipped.
  a_skip_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.skipped_points <= hfe_pkg::SKIP_W'(16))
    else $error("skipped corner count out of range");

  // The strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

bind haar_feature_evaluator_core hfe_checker u_hfe_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire

// File: tb/sv/tb_haar_feature_evaluator_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_haar_feature_evaluator_core: self-checking bench for the Haar evaluator
// Loads integral image entries, evaluates every feature kind at the edges of
// the field ranges and under several image sizes, then runs random traffic
// with varied sender idling. Each result is checked field by field against
// an in-bench prediction of the feature response and skipped corner count.
// ============================================================================
module tb_haar_feature_evaluator_core;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 9;
  localparam int DIM              = hfe_pkg::MAX_DIM_DEFAULT;
  localparam int STORE_AW         = $clog2(DIM * DIM);
  localparam int MAX_CORNERS      = 16;
  // The slowest evaluation, the checker, keeps busy high longest and its
  // result comes as busy falls, so this is enough for the block to fall idle.
  localparam int SETTLE_CYCLES    = 24;
  localparam int DRAIN_LIMIT      = 400;
  localparam int STALL_LIMIT      = 5000;
  // Missing corners are loaded before each evaluation, which adds roughly as
  // many entry loads again on top of the random items.
  localparam int RANDOM_PER_PHASE = 90;
  localparam int RANDOM_PHASES    = 5;

  // Register indexes past the two image size registers; writes to them must
  // leave the configuration untouched.
  localparam logic [hfe_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [hfe_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // Kind codes that name no feature; each still yields one all-zero result.
  localparam logic [hfe_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [hfe_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  localparam logic [hfe_pkg::VALUE_W-1:0] VALUE_MAX = {hfe_pkg::VALUE_W{1'b1}};

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  hfe_pkg::hfe_item_t            item;
  logic                          done;
  hfe_pkg::hfe_result_t          result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hfe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hfe_pkg::LIMIT_W-1:0]   cfg_data;

  haar_feature_evaluator_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the block's state: the integral image, which entries have
  // been loaded so far, and the two image size registers.
  // --------------------------------------------------------------------------
  logic [hfe_pkg::VALUE_W-1:0] integral_store [DIM*DIM];
  bit                          entry_loaded   [DIM*DIM];
  logic [hfe_pkg::LIMIT_W-1:0] image_cols = hfe_pkg::LIMIT_W'(32);
  logic [hfe_pkg::LIMIT_W-1:0] image_rows = hfe_pkg::LIMIT_W'(32);

  // Feature responses still owed by the block, oldest first.
  hfe_pkg::hfe_result_t expected_responses [$];

  // Corner plan of the feature currently being worked out: position and the
  // sign with which its entry enters the sum.
  int plan_n;
  int plan_col [MAX_CORNERS];
  int plan_row [MAX_CORNERS];
  int plan_sgn [MAX_CORNERS];

  int send_idle_pct = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;
  int writes_sent   = 0;
  int evals_sent    = 0;
  int reg_writes    = 0;
  int results_seen  = 0;
  int skip_results  = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Position of an entry in the bench copy of the store.
  function automatic logic [STORE_AW-1:0] entry_index(int col, int row);
    return STORE_AW'(row * DIM + col);
  endfunction

  // A size register above the store dimension behaves as the full dimension.
  function automatic int image_limit(logic [hfe_pkg::LIMIT_W-1:0] size);
    return (int'(size) > DIM) ? DIM : int'(size);
  endfunction

  function automatic bit in_image(int col, int row);
    return (col < image_limit(image_cols)) && (row < image_limit(image_rows));
  endfunction

  function automatic void add_corner(int col, int row, int sgn);
    plan_col[plan_n] = col;
    plan_row[plan_n] = row;
    plan_sgn[plan_n] = sgn;
    plan_n++;
  endfunction

  // A rectangle contributes its four corners: the top-left and bottom-right
  // with the rectangle's sign and the other two with the opposite sign.
  function automatic void add_rect(int x0, int y0, int x1, int y1, int sgn);
    add_corner(x0, y0, sgn);
    add_corner(x1, y0, -sgn);
    add_corner(x0, y1, -sgn);
    add_corner(x1, y1, sgn);
  endfunction

  // Splits the feature into its rectangles. Halves and thirds truncate, so
  // for odd or non-multiple sizes the last band takes the remainder.
  function automatic void plan_feature(hfe_pkg::hfe_item_t it);
    int x;
    int y;
    int w;
    int h;
    int hw;
    int hh;
    int tw;
    int th;
    x  = int'(it.feature_left);
    y  = int'(it.feature_top);
    w  = int'(it.feature_width);
    h  = int'(it.feature_height);
    hw = w / 2;
    hh = h / 2;
    tw = w / 3;
    th = h / 3;
    plan_n = 0;
    case (it.feature_kind)
      hfe_pkg::KIND_TWO_H: begin
        add_rect(x, y, x + hw, y + h, 1);
        add_rect(x + hw, y, x + w, y + h, -1);
      end
      hfe_pkg::KIND_TWO_V: begin
        add_rect(x, y, x + w, y + hh, -1);
        add_rect(x, y + hh, x + w, y + h, 1);
      end
      hfe_pkg::KIND_THREE_H: begin
        add_rect(x, y, x + tw, y + h, -1);
        add_rect(x + tw, y, x + 2 * tw, y + h, 1);
        add_rect(x + 2 * tw, y, x + w, y + h, -1);
      end
      hfe_pkg::KIND_THREE_V: begin
        add_rect(x, y, x + w, y + th, -1);
        add_rect(x, y + th, x + w, y + 2 * th, 1);
        add_rect(x, y + 2 * th, x + w, y + h, -1);
      end
      hfe_pkg::KIND_CHECKER: begin
        add_rect(x, y, x + hw, y + hh, 1);
        add_rect(x + hw, y, x + w, y + hh, -1);
        add_rect(x, y + hh, x + hw, y + h, -1);
        add_rect(x + hw, y + hh, x + w, y + h, 1);
      end
      default: begin
      end
    endcase
  endfunction

  // Signed corner sum over the corners inside the image; the rest are only
  // counted. The response wraps to its field width.
  function automatic hfe_pkg::hfe_result_t predict_response(hfe_pkg::hfe_item_t it);
    longint               acc;
    int                   skipped;
    longint               entry;
    hfe_pkg::hfe_result_t r;
    acc     = 0;
    skipped = 0;
    plan_feature(it);
    for (int i = 0; i < plan_n; i++) begin
      if (in_image(plan_col[i], plan_row[i])) begin
        entry = longint'(integral_store[entry_index(plan_col[i], plan_row[i])]);
        if (plan_sgn[i] > 0) begin
          acc += entry;
        end else begin
          acc -= entry;
        end
      end else begin
        skipped++;
      end
    end
    r.response       = acc[hfe_pkg::RESPONSE_W-1:0];
    r.skipped_points = skipped[hfe_pkg::SKIP_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item generation
  // --------------------------------------------------------------------------

  // Every field random; callers then fix the ones that matter. Fields that
  // the command ignores stay random so that their bits toggle too.
  function automatic hfe_pkg::hfe_item_t scrambled_item();
    hfe_pkg::hfe_item_t it;
    it.cmd            = 1'($urandom_range(0, 1));
    it.entry_col      = hfe_pkg::COORD_W'($urandom_range(0, DIM - 1));
    it.entry_row      = hfe_pkg::COORD_W'($urandom_range(0, DIM - 1));
    it.entry_value    = hfe_pkg::VALUE_W'($urandom_range(0, VALUE_MAX));
    it.feature_kind   = hfe_pkg::KIND_W'($urandom_range(0, KIND_UNUSED_LAST));
    it.feature_left   = hfe_pkg::COORD_W'($urandom_range(0, DIM - 1));
    it.feature_top    = hfe_pkg::COORD_W'($urandom_range(0, DIM - 1));
    it.feature_width  = hfe_pkg::COORD_W'($urandom_range(0, DIM - 1));
    it.feature_height = hfe_pkg::COORD_W'($urandom_range(0, DIM - 1));
    return it;
  endfunction

  // Roughly a third of the traffic loads entries. Half of the evaluations
  // are fitted inside the current image so that all corners get summed; the
  // other half land anywhere and exercise corner skipping.
  function automatic hfe_pkg::hfe_item_t random_item();
    hfe_pkg::hfe_item_t it;
    int                 lw;
    int                 lh;
    it = scrambled_item();
    if ($urandom_range(0, 99) < 30) begin
      it.cmd = hfe_pkg::CMD_WRITE;
      return it;
    end
    it.cmd = hfe_pkg::CMD_EVALUATE;
    if ($urandom_range(0, 9) == 0) begin
      it.feature_kind = hfe_pkg::KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end else begin
      it.feature_kind = hfe_pkg::KIND_W'($urandom_range(hfe_pkg::KIND_TWO_H,
                                                         hfe_pkg::KIND_CHECKER));
    end
    lw = image_limit(image_cols);
    lh = image_limit(image_rows);
    if ($urandom_range(0, 1) == 1 && lw > 0 && lh > 0) begin
      it.feature_left   = hfe_pkg::COORD_W'($urandom_range(0, lw - 1));
      it.feature_top    = hfe_pkg::COORD_W'($urandom_range(0, lh - 1));
      it.feature_width  = hfe_pkg::COORD_W'($urandom_range(0, lw - 1 - int'(it.feature_left)));
      it.feature_height = hfe_pkg::COORD_W'($urandom_range(0, lh - 1 - int'(it.feature_top)));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Presents one item and waits for its transfer. Start is left high after
  // the transfer; the next call either replaces the item in the same step or
  // idles, and every pause lowers start first. That keeps start from being
  // lowered and raised within one time step.
  task automatic send_item(input hfe_pkg::hfe_item_t it);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    // Busy read here is the value before this edge, as the block saw it.
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
    if (it.cmd == hfe_pkg::CMD_WRITE) begin
      integral_store[entry_index(int'(it.entry_col), int'(it.entry_row))] = it.entry_value;
      entry_loaded[entry_index(int'(it.entry_col), int'(it.entry_row))]   = 1'b1;
      writes_sent++;
    end else begin
      expected_responses = {expected_responses, predict_response(it)};
      evals_sent++;
    end
  endtask

  task automatic write_entry(input int col, input int row,
                             input logic [hfe_pkg::VALUE_W-1:0] value);
    hfe_pkg::hfe_item_t it;
    it             = scrambled_item();
    it.cmd         = hfe_pkg::CMD_WRITE;
    it.entry_col   = hfe_pkg::COORD_W'(col);
    it.entry_row   = hfe_pkg::COORD_W'(row);
    it.entry_value = value;
    send_item(it);
  endtask

  // Reading an entry that was never loaded is outside the block's contract,
  // so before an evaluation every summed corner that is still empty gets a
  // random value loaded first.
  task automatic load_missing_corners(input hfe_pkg::hfe_item_t it);
    int n;
    int cols [MAX_CORNERS];
    int rows [MAX_CORNERS];
    plan_feature(it);
    n = plan_n;
    for (int i = 0; i < n; i++) begin
      cols[i] = plan_col[i];
      rows[i] = plan_row[i];
    end
    for (int i = 0; i < n; i++) begin
      if (in_image(cols[i], rows[i]) && !entry_loaded[entry_index(cols[i], rows[i])]) begin
        write_entry(cols[i], rows[i], hfe_pkg::VALUE_W'($urandom_range(0, VALUE_MAX)));
      end
    end
  endtask

  task automatic issue_item(input hfe_pkg::hfe_item_t it);
    if (it.cmd == hfe_pkg::CMD_EVALUATE) begin
      load_missing_corners(it);
    end
    send_item(it);
  endtask

  task automatic send_feature(input logic [hfe_pkg::KIND_W-1:0] kind, input int left,
                              input int top, input int width, input int height);
    hfe_pkg::hfe_item_t it;
    it                = scrambled_item();
    it.cmd            = hfe_pkg::CMD_EVALUATE;
    it.feature_kind   = kind;
    it.feature_left   = hfe_pkg::COORD_W'(left);
    it.feature_top    = hfe_pkg::COORD_W'(top);
    it.feature_width  = hfe_pkg::COORD_W'(width);
    it.feature_height = hfe_pkg::COORD_W'(height);
    issue_item(it);
  endtask

  // Stops issuing, waits for every owed result, then gives the block enough
  // cycles to finish a trailing write. Results that never show up are
  // reported once and dropped.
  task automatic settle_block();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (expected_responses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_responses.size() != 0) begin
      $error("%0d evaluations never produced a result", expected_responses.size());
      fail_count++;
      expected_responses.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Like start, cfg_valid stays high across back-to-back register writes and
  // is lowered by the caller once the last one has gone through.
  task automatic write_register(input logic [hfe_pkg::CFG_IDX_W-1:0] index,
                                input logic [hfe_pkg::LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    reg_writes++;
    if (index == hfe_pkg::REG_IMAGE_WIDTH) begin
      image_cols = value;
    end else if (index == hfe_pkg::REG_IMAGE_HEIGHT) begin
      image_rows = value;
    end
  endtask

  task automatic set_image_size(input logic [hfe_pkg::LIMIT_W-1:0] cols,
                                input logic [hfe_pkg::LIMIT_W-1:0] rows);
    settle_block();
    write_register(hfe_pkg::REG_IMAGE_WIDTH, cols);
    write_register(hfe_pkg::REG_IMAGE_HEIGHT, rows);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checking: every strobed result is taken on the edge that ends its
  // cycle and compared with the oldest owed response.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hfe_pkg::hfe_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_responses.size() == 0) begin
        $error("result with no evaluation outstanding: response %0d, skipped_points %0d",
               result.response, result.skipped_points);
        fail_count++;
      end else begin
        want = expected_responses.pop_front();
        results_seen++;
        if (want.skipped_points != 0) begin
          skip_results++;
        end
        if (result.response !== want.response) begin
          $error("response: expected %0d, got %0d", want.response, result.response);
          fail_count++;
        end
        if (result.skipped_points !== want.skipped_points) begin
          $error("skipped_points: expected %0d, got %0d",
                 want.skipped_points, result.skipped_points);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transfer, result or register write counts as progress. A
  // long quiet stretch means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Runs under the reset image size of 32 by 32, which checks those defaults
  // too. Covers each kind, truncation of halves and thirds, empty features,
  // a feature hanging off the far corner, and the kinds that name nothing.
  task automatic test_directed_features();
    // Extreme entry values at the four image corners, then a two-rectangle
    // feature spanning the whole image that sums all four of them.
    write_entry(0, 0, VALUE_MAX);
    write_entry(DIM - 1, DIM - 1, VALUE_MAX);
    write_entry(DIM - 1, 0, '0);
    write_entry(0, DIM - 1, '0);
    send_feature(hfe_pkg::KIND_TWO_H, 0, 0, 31, 31);
    for (int k = int'(hfe_pkg::KIND_TWO_H); k <= int'(hfe_pkg::KIND_CHECKER); k++) begin
      send_feature(hfe_pkg::KIND_W'(k), 4, 4, 6, 6);
    end
    // Sizes that leave a remainder after halving or splitting in three.
    send_feature(hfe_pkg::KIND_THREE_H, 2, 3, 7, 5);
    send_feature(hfe_pkg::KIND_THREE_V, 3, 2, 5, 8);
    send_feature(hfe_pkg::KIND_TWO_H, 1, 1, 5, 3);
    send_feature(hfe_pkg::KIND_TWO_V, 1, 1, 3, 5);
    send_feature(hfe_pkg::KIND_THREE_H, 9, 9, 2, 2);
    // Zero-sized feature: all corners coincide and cancel.
    send_feature(hfe_pkg::KIND_CHECKER, 9, 9, 0, 0);
    // Largest offsets: every corner but the top-left falls outside.
    send_feature(hfe_pkg::KIND_CHECKER, 31, 31, 31, 31);
    for (int k = int'(KIND_UNUSED_FIRST); k <= int'(KIND_UNUSED_LAST); k++) begin
      send_feature(hfe_pkg::KIND_W'(k), $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                   $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
    end
  endtask

  // Bounds checking across image sizes: zero skips every corner, sizes above
  // the store dimension act as the full dimension, and writes to the spare
  // register indexes change nothing.
  task automatic test_image_limits();
    set_image_size(hfe_pkg::LIMIT_W'(0), hfe_pkg::LIMIT_W'(63));
    send_feature(hfe_pkg::KIND_CHECKER, 0, 0, 4, 4);
    send_feature(hfe_pkg::KIND_TWO_V, 3, 1, 2, 6);
    set_image_size(hfe_pkg::LIMIT_W'(63), hfe_pkg::LIMIT_W'(0));
    send_feature(hfe_pkg::KIND_THREE_H, 0, 0, 9, 3);
    set_image_size(hfe_pkg::LIMIT_W'(1), hfe_pkg::LIMIT_W'(1));
    send_feature(hfe_pkg::KIND_CHECKER, 0, 0, 2, 2);
    send_feature(hfe_pkg::KIND_TWO_H, 0, 0, 0, 0);
    set_image_size(hfe_pkg::LIMIT_W'(33), hfe_pkg::LIMIT_W'(17));
    send_feature(hfe_pkg::KIND_THREE_V, 20, 10, 11, 9);
    settle_block();
    write_register(REG_SPARE_LO, hfe_pkg::LIMIT_W'(5));
    write_register(REG_SPARE_HI, hfe_pkg::LIMIT_W'(42));
    cfg_valid <= 1'b0;
    send_feature(hfe_pkg::KIND_THREE_V, 20, 10, 11, 9);
    send_feature(hfe_pkg::KIND_TWO_H, 28, 14, 8, 6);
  endtask

  // Random traffic in phases, each with its own image size and sender idle
  // rate, including stretches where items arrive back to back.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          set_image_size(hfe_pkg::LIMIT_W'(32), hfe_pkg::LIMIT_W'(32));
          send_idle_pct = 0;
        end
        1: begin
          set_image_size(hfe_pkg::LIMIT_W'($urandom_range(1, DIM)),
                         hfe_pkg::LIMIT_W'($urandom_range(1, DIM)));
          send_idle_pct = 79;
        end
        2: begin
          set_image_size(hfe_pkg::LIMIT_W'(1), hfe_pkg::LIMIT_W'(32));
          send_idle_pct = 25;
        end
        3: begin
          set_image_size(hfe_pkg::LIMIT_W'(32), hfe_pkg::LIMIT_W'(1));
          send_idle_pct = 0;
        end
        default: begin
          set_image_size(hfe_pkg::LIMIT_W'($urandom_range(1, DIM)),
                         hfe_pkg::LIMIT_W'($urandom_range(1, DIM)));
          send_idle_pct = 79;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        issue_item(random_item());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_features();
    test_image_limits();
    test_random_traffic();
    settle_block();

    $display("Covered %0d item transfers: %0d entry loads and %0d feature evaluations.",
             items_sent, writes_sent, evals_sent);
    $display("Checked %0d results, %0d with skipped corners, over %0d register writes.",
             results_seen, skip_results, reg_writes);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
